@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/iau_pkg.sv @@
`default_nettype none
package iau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ZG_BITS   = 16;

  // product magnitude of two word magnitudes (each at most 2^(W-1))
  localparam int PROD_BITS = 2 * WORD_BITS - 1;
  // quotient bits of 2^(2F) / m, and root bits of (m << F)
  localparam int QUO_BITS  = 2 * FRAC_BITS + 1;
  localparam int ROOT_BITS = (WORD_BITS + FRAC_BITS) / 2;
  localparam int N_CELLS   = (QUO_BITS > ROOT_BITS) ? QUO_BITS : ROOT_BITS;
  localparam int SRC_BITS  = 2 * N_CELLS;
  localparam int ACC_BITS  = ((N_CELLS + 3) > (WORD_BITS + 1)) ? (N_CELLS + 3)
                                                               : (WORD_BITS + 1);
  localparam int MAG_BITS  = ((PROD_BITS > N_CELLS) ? PROD_BITS : N_CELLS) + 1;

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [N_CELLS-1:0]   DIVIDEND = N_CELLS'(1) << (2 * FRAC_BITS);
  localparam logic [PROD_BITS-1:0] FRAC_MASK =
    {PROD_BITS{1'b1}} >> (PROD_BITS - FRAC_BITS);

  // opcodes
  localparam logic [3:0] MODE_PASS  = 4'd0;
  localparam logic [3:0] MODE_NEG   = 4'd1;
  localparam logic [3:0] MODE_SCALE = 4'd2;
  localparam logic [3:0] MODE_TRANS = 4'd3;
  localparam logic [3:0] MODE_ADD   = 4'd4;
  localparam logic [3:0] MODE_SUB   = 4'd5;
  localparam logic [3:0] MODE_MUL   = 4'd6;
  localparam logic [3:0] MODE_SQR   = 4'd7;
  localparam logic [3:0] MODE_INV   = 4'd8;
  localparam logic [3:0] MODE_SQRT  = 4'd9;
  localparam logic [3:0] MODE_WIDTH = 4'd10;

  // where the final result comes from
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_DIV    = 2'd2;
  localparam logic [1:0] KIND_SQRT   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SAT    = 2'd1;
  localparam logic [1:0] ST_DOMAIN = 2'd2;

  // product lanes: A/B feed the lower bound, C/D the upper bound
  localparam int LN_A = 0;
  localparam int LN_B = 1;
  localparam int LN_C = 2;
  localparam int LN_D = 3;

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] val;
  } res_t;

  // one divide / square-root lane as it walks the cell chain
  typedef struct packed {
    logic [ACC_BITS-1:0]  acc;
    logic [SRC_BITS-1:0]  src;
    logic [N_CELLS-1:0]   q;
    logic [WORD_BITS-1:0] den;
  } lane_t;

  // everything else that rides along with the item
  typedef struct packed {
    logic [1:0]                kind;
    logic [WORD_BITS-1:0]      dlo;
    logic [WORD_BITS-1:0]      dhi;
    logic                      dsat;
    logic                      domain;
    logic [3:0]                pneg;
    logic [3:0][PROD_BITS-1:0] prod;
    logic                      use_b;
    logic                      use_d;
    logic                      lneg;
    logic                      hneg;
    logic                      lzero;
    logic                      hzero;
  } side_t;

  typedef struct packed {
    logic  is_sqrt;
    lane_t lo;
    lane_t hi;
    side_t side;
  } cell_t;

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] x);
    mag = x[WORD_BITS-1] ? WORD_BITS'('0 - x) : x;
  endfunction

  // clamp a one-bit-wider signed sum to the word range
  function automatic res_t sat_w(input logic [WORD_BITS:0] v);
    res_t r;
    r.sat = 1'b0;
    r.val = v[WORD_BITS-1:0];
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r.sat = 1'b1;
      r.val = v[WORD_BITS] ? WMIN : WMAX;
    end
    sat_w = r;
  endfunction

  // signed word from a sign and a magnitude, clamped
  function automatic res_t from_mag(input logic neg, input logic [MAG_BITS-1:0] m);
    res_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (m > MAG_BITS'(WMAX)) begin
        r.sat = 1'b1;
        r.val = WMAX;
      end else begin
        r.val = m[WORD_BITS-1:0];
      end
    end else begin
      if (m > (MAG_BITS'(1) << (WORD_BITS - 1))) begin
        r.sat = 1'b1;
        r.val = WMIN;
      end else begin
        r.val = '0 - m[WORD_BITS-1:0];
      end
    end
    from_mag = r;
  endfunction

  // rescale a product magnitude, rounding outward
  function automatic res_t fmul_fin(input logic neg, input logic [PROD_BITS-1:0] p,
                                    input logic up);
    logic                inc;
    logic [MAG_BITS-1:0] m;
    inc = ((p & FRAC_MASK) != '0) && (up != neg);
    m = MAG_BITS'(p >> FRAC_BITS) + MAG_BITS'(inc);
    fmul_fin = from_mag(neg, m);
  endfunction

endpackage
`default_nettype wire

@@ sv/iau_front.sv @@
`default_nettype none
// Decode, operand selection, direct results and the four product lanes.
module iau_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [iau_pkg::ZG_BITS-1:0]       zero_guard,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [3:0]                        in_mode,
  input  wire logic [5*iau_pkg::WORD_BITS-1:0]   in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output iau_pkg::cell_t                         out_data
);
  localparam int W = iau_pkg::WORD_BITS;

  logic            v_r;
  iau_pkg::cell_t  d_r, d_nxt;

  logic [W-1:0] bl, bh, cl, ch, ts;
  logic [W:0]   bl_x, bh_x, cl_x, ch_x, ts_x, gs, wd;
  logic [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic [2*W-1:0] pa, pb, pc, pd;
  iau_pkg::res_t r0, r1;
  logic near_zero;

  assign bl = in_data[0*W +: W];
  assign bh = in_data[1*W +: W];
  assign cl = in_data[2*W +: W];
  assign ch = in_data[3*W +: W];
  assign ts = in_data[4*W +: W];
  assign bl_x = {bl[W-1], bl};
  assign bh_x = {bh[W-1], bh};
  assign cl_x = {cl[W-1], cl};
  assign ch_x = {ch[W-1], ch};
  assign ts_x = {ts[W-1], ts};
  assign gs   = {{(W+1-iau_pkg::ZG_BITS){1'b0}}, zero_guard};
  assign wd   = bh_x - bl_x;
  assign near_zero = ($signed(bl_x) <= $signed(gs)) && ($signed(bh_x) >= -$signed(gs));

  // product operand selection (unused lanes multiply zero)
  always_comb begin
    ax = '0; ay = '0; bx = '0; by = '0;
    cx = '0; cy = '0; dx = '0; dy = '0;
    case (in_mode)
      iau_pkg::MODE_SCALE: begin
        ax = ts; cx = ts;
        if ($signed(ts) > 0) begin
          ay = bl; cy = bh;
        end else begin
          ay = bh; cy = bl;
        end
      end
      iau_pkg::MODE_SQR: begin
        if (!bl[W-1]) begin
          ax = bl; ay = bl; cx = bh; cy = bh;
        end else if ($signed(bh) <= 0) begin
          ax = bh; ay = bh; cx = bl; cy = bl;
        end else begin
          cx = bl; cy = bl; dx = bh; dy = bh;
        end
      end
      iau_pkg::MODE_MUL: begin
        if (!bl[W-1]) begin
          if (!cl[W-1]) begin
            ax = bl; ay = cl; cx = bh; cy = ch;
          end else if ($signed(ch) <= 0) begin
            ax = bh; ay = cl; cx = bl; cy = ch;
          end else begin
            ax = bh; ay = cl; cx = bh; cy = ch;
          end
        end else if ($signed(bh) <= 0) begin
          if (!cl[W-1]) begin
            ax = bl; ay = ch; cx = bh; cy = cl;
          end else if ($signed(ch) <= 0) begin
            ax = bh; ay = ch; cx = bl; cy = cl;
          end else begin
            ax = bl; ay = ch; cx = bl; cy = cl;
          end
        end else begin
          if (!cl[W-1]) begin
            ax = bl; ay = ch; cx = bh; cy = ch;
          end else if ($signed(ch) <= 0) begin
            ax = bh; ay = cl; cx = bl; cy = cl;
          end else begin
            ax = bl; ay = ch; bx = bh; by = cl;
            cx = bl; cy = cl; dx = bh; dy = ch;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // four magnitude multipliers
  assign pa = (2*W)'(iau_pkg::mag(ax)) * (2*W)'(iau_pkg::mag(ay));
  assign pb = (2*W)'(iau_pkg::mag(bx)) * (2*W)'(iau_pkg::mag(by));
  assign pc = (2*W)'(iau_pkg::mag(cx)) * (2*W)'(iau_pkg::mag(cy));
  assign pd = (2*W)'(iau_pkg::mag(dx)) * (2*W)'(iau_pkg::mag(dy));

  // direct results, kinds and lane seeds
  always_comb begin
    d_nxt = '0;
    r0 = '0;
    r1 = '0;
    d_nxt.side.prod[iau_pkg::LN_A] = pa[iau_pkg::PROD_BITS-1:0];
    d_nxt.side.prod[iau_pkg::LN_B] = pb[iau_pkg::PROD_BITS-1:0];
    d_nxt.side.prod[iau_pkg::LN_C] = pc[iau_pkg::PROD_BITS-1:0];
    d_nxt.side.prod[iau_pkg::LN_D] = pd[iau_pkg::PROD_BITS-1:0];
    d_nxt.side.pneg = {dx[W-1] ^ dy[W-1], cx[W-1] ^ cy[W-1],
                       bx[W-1] ^ by[W-1], ax[W-1] ^ ay[W-1]};
    d_nxt.side.kind = iau_pkg::KIND_DIRECT;
    case (in_mode)
      iau_pkg::MODE_PASS: begin
        r0.val = bl; r1.val = bh;
      end
      iau_pkg::MODE_NEG: begin
        r0 = iau_pkg::sat_w(-bh_x); r1 = iau_pkg::sat_w(-bl_x);
      end
      iau_pkg::MODE_TRANS: begin
        r0 = iau_pkg::sat_w(ts_x + bl_x); r1 = iau_pkg::sat_w(ts_x + bh_x);
      end
      iau_pkg::MODE_ADD: begin
        r0 = iau_pkg::sat_w(bl_x + cl_x); r1 = iau_pkg::sat_w(bh_x + ch_x);
      end
      iau_pkg::MODE_SUB: begin
        r0 = iau_pkg::sat_w(bl_x - ch_x); r1 = iau_pkg::sat_w(bh_x - cl_x);
      end
      iau_pkg::MODE_WIDTH: begin
        // |bh - bl|, saturated at the top of the range
        if (wd[W]) begin
          r0 = iau_pkg::sat_w(-wd);
        end else begin
          r0 = iau_pkg::sat_w(wd);
        end
      end
      iau_pkg::MODE_SCALE, iau_pkg::MODE_MUL, iau_pkg::MODE_SQR: begin
        d_nxt.side.kind = iau_pkg::KIND_MUL;
        d_nxt.side.use_b = (in_mode == iau_pkg::MODE_MUL) && bl[W-1] &&
                           ($signed(bh) > 0) && cl[W-1] && ($signed(ch) > 0);
        d_nxt.side.use_d = d_nxt.side.use_b ||
                           ((in_mode == iau_pkg::MODE_SQR) && bl[W-1] && ($signed(bh) > 0));
      end
      iau_pkg::MODE_INV: begin
        if (near_zero) begin
          r0.val = iau_pkg::WMIN; r1.val = iau_pkg::WMAX;
        end else begin
          d_nxt.side.kind  = iau_pkg::KIND_DIV;
          d_nxt.side.lneg  = bh[W-1];
          d_nxt.side.hneg  = bl[W-1];
          d_nxt.side.lzero = (bh == '0);
          d_nxt.side.hzero = (bl == '0);
          d_nxt.lo.src = {iau_pkg::DIVIDEND, {iau_pkg::N_CELLS{1'b0}}};
          d_nxt.hi.src = {iau_pkg::DIVIDEND, {iau_pkg::N_CELLS{1'b0}}};
          d_nxt.lo.den = iau_pkg::mag(bh);
          d_nxt.hi.den = iau_pkg::mag(bl);
        end
      end
      iau_pkg::MODE_SQRT: begin
        if (bh[W-1]) begin
          d_nxt.side.domain = 1'b1;
        end else begin
          d_nxt.side.kind = iau_pkg::KIND_SQRT;
          d_nxt.is_sqrt   = 1'b1;
          if ($signed(bl) > 0) begin
            d_nxt.lo.src = iau_pkg::SRC_BITS'(bl) << iau_pkg::FRAC_BITS;
          end
          if ($signed(bh) > 0) begin
            d_nxt.hi.src = iau_pkg::SRC_BITS'(bh) << iau_pkg::FRAC_BITS;
          end
        end
      end
      default: begin
      end
    endcase
    d_nxt.side.dlo  = r0.val;
    d_nxt.side.dhi  = r1.val;
    d_nxt.side.dsat = r0.sat | r1.sat;
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/iau_cell.sv @@
`default_nettype none
// One step of the chain: a restoring divide bit or a square-root digit
// on each of the two lanes; side data passes through.
module iau_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire iau_pkg::cell_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output iau_pkg::cell_t       out_data
);
  localparam int A = iau_pkg::ACC_BITS;
  localparam int S = iau_pkg::SRC_BITS;
  localparam int N = iau_pkg::N_CELLS;

  function automatic iau_pkg::lane_t step(input iau_pkg::lane_t l, input logic sq);
    iau_pkg::lane_t o;
    logic [A-1:0]   r;
    logic [A-1:0]   t;
    logic           ge;
    o = l;
    if (sq) begin
      r = {l.acc[A-3:0], l.src[S-1 -: 2]};
      t = A'({l.q, 2'b01});
      o.src = l.src << 2;
    end else begin
      r = {l.acc[A-2:0], l.src[S-1]};
      t = A'(l.den);
      o.src = l.src << 1;
    end
    ge = (r >= t);
    o.acc = ge ? (r - t) : r;
    o.q = {l.q[N-2:0], ge};
    step = o;
  endfunction

  logic            v_r;
  iau_pkg::cell_t  d_r, d_nxt;

  always_comb begin
    d_nxt = in_data;
    d_nxt.lo = step(in_data.lo, in_data.is_sqrt);
    d_nxt.hi = step(in_data.hi, in_data.is_sqrt);
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/iau_back.sv @@
`default_nettype none
// Rounding, saturation, bound selection and the output register.
module iau_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire iau_pkg::cell_t              in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2*iau_pkg::WORD_BITS-1:0]  out_data,
  output logic [1:0]                       out_status
);
  localparam int W = iau_pkg::WORD_BITS;
  localparam int M = iau_pkg::MAG_BITS;

  function automatic iau_pkg::res_t recip_fin(input iau_pkg::lane_t l, input logic neg,
                                              input logic zero, input logic up);
    iau_pkg::res_t r;
    logic          inc;
    inc = (l.acc != '0) && (up != neg);
    r = iau_pkg::from_mag(neg, M'(l.q) + M'(inc));
    if (zero) begin
      r.sat = 1'b1;
      r.val = up ? iau_pkg::WMAX : iau_pkg::WMIN;
    end
    recip_fin = r;
  endfunction

  function automatic iau_pkg::res_t sqrt_fin(input iau_pkg::lane_t l, input logic up);
    sqrt_fin = iau_pkg::from_mag(1'b0, M'(l.q) + M'(up && (l.acc != '0)));
  endfunction

  logic           v_r;
  logic [W-1:0]   lo_r, hi_r, lo_nxt, hi_nxt;
  logic [1:0]     st_r, st_nxt;
  iau_pkg::res_t  ra, rb, rc, rd, rl, rh;
  logic           sat;
  iau_pkg::side_t sd;

  assign sd = in_data.side;

  always_comb begin
    ra = iau_pkg::fmul_fin(sd.pneg[iau_pkg::LN_A], sd.prod[iau_pkg::LN_A], 1'b0);
    rb = iau_pkg::fmul_fin(sd.pneg[iau_pkg::LN_B], sd.prod[iau_pkg::LN_B], 1'b0);
    rc = iau_pkg::fmul_fin(sd.pneg[iau_pkg::LN_C], sd.prod[iau_pkg::LN_C], 1'b1);
    rd = iau_pkg::fmul_fin(sd.pneg[iau_pkg::LN_D], sd.prod[iau_pkg::LN_D], 1'b1);
    rl = '0;
    rh = '0;
    lo_nxt = sd.dlo;
    hi_nxt = sd.dhi;
    sat = sd.dsat;
    case (sd.kind)
      iau_pkg::KIND_MUL: begin
        lo_nxt = (sd.use_b && ($signed(rb.val) < $signed(ra.val))) ? rb.val : ra.val;
        hi_nxt = (sd.use_d && ($signed(rd.val) > $signed(rc.val))) ? rd.val : rc.val;
        sat = ra.sat | rb.sat | rc.sat | rd.sat;
      end
      iau_pkg::KIND_DIV: begin
        rl = recip_fin(in_data.lo, sd.lneg, sd.lzero, 1'b0);
        rh = recip_fin(in_data.hi, sd.hneg, sd.hzero, 1'b1);
        lo_nxt = rl.val;
        hi_nxt = rh.val;
        sat = rl.sat | rh.sat;
      end
      iau_pkg::KIND_SQRT: begin
        rl = sqrt_fin(in_data.lo, 1'b0);
        rh = sqrt_fin(in_data.hi, 1'b1);
        lo_nxt = rl.val;
        hi_nxt = rh.val;
        sat = rl.sat | rh.sat;
      end
      default: begin
      end
    endcase
    if (sd.domain) begin
      st_nxt = iau_pkg::ST_DOMAIN;
    end else if (sat) begin
      st_nxt = iau_pkg::ST_SAT;
    end else begin
      st_nxt = iau_pkg::ST_OK;
    end
  end

  assign in_ready   = !v_r || out_ready;
  assign out_valid  = v_r;
  assign out_data   = {hi_r, lo_r};
  assign out_status = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/interval_arithmetic_unit.sv @@
// Interval arithmetic unit, signed Q16.16. Takes one item per clock while
// the output is not stalled and returns one result item per input item, in
// order. It is built from one decode/multiply stage, a chain of 33
// divide/square-root cells and one rounding/output stage. The 33-cell chain
// yields one quotient or root bit per cell; every stage is pipelined, so
// throughput is one item per cycle for all opcodes while the output is not
// stalled. Write zero_guard through cfg_we/cfg_wdata only while no item is in flight.
`default_nettype none
`include "assert_macros.svh"
module interval_arithmetic_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [iau_pkg::ZG_BITS-1:0]       cfg_wdata,   // zero_guard
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // b_low, b_high, c_low, c_high, scalar (low bits first)
  input  wire logic [5*iau_pkg::WORD_BITS-1:0]   in_tdata,
  input  wire logic [3:0]                        in_tuser,    // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // res_low, res_high (low bits first)
  output logic [2*iau_pkg::WORD_BITS-1:0]        out_tdata,
  output logic [1:0]                             out_tuser    // status
);
  localparam int N = iau_pkg::N_CELLS;

  logic [iau_pkg::ZG_BITS-1:0] zg_r;
  iau_pkg::cell_t stg [0:N];
  logic           vld [0:N];
  logic           rdy [0:N];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zg_r <= '0;
    end else if (cfg_we) begin
      zg_r <= cfg_wdata;
    end
  end

  iau_front u_front (
    .clk(clk), .rst_n(rst_n), .zero_guard(zg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tuser), .in_data(in_tdata),
    .out_valid(vld[0]), .out_ready(rdy[0]), .out_data(stg[0])
  );

  // divide / square-root chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    iau_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(vld[i]), .in_ready(rdy[i]), .in_data(stg[i]),
      .out_valid(vld[i+1]), .out_ready(rdy[i+1]), .out_data(stg[i+1])
    );
  end

  iau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(vld[N]), .in_ready(rdy[N]), .in_data(stg[N]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata), .out_status(out_tuser)
  );

  `AST_IMPLIES(a_dom_zero, clk, rst_n, out_tvalid && (out_tuser == iau_pkg::ST_DOMAIN), out_tdata == '0, "domain result not zero")
  `AST_IMPLIES(a_stall_src, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled without output backpressure")
  `AST_IMPLIES(a_status_code, clk, rst_n, out_tvalid, out_tuser == iau_pkg::ST_OK || out_tuser == iau_pkg::ST_SAT || out_tuser == iau_pkg::ST_DOMAIN, "bad status code")
  `AST_NEXT(a_cfg_write, clk, rst_n, cfg_we, zg_r == $past(cfg_wdata), "zero guard not written")

endmodule
`default_nettype wire

@@ sim/interval_arithmetic_unit_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module interval_arithmetic_unit_test;

  localparam int W = iau_pkg::WORD_BITS;
  localparam int F = iau_pkg::FRAC_BITS;
  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [3:0]          mode;
    logic signed [W-1:0] bl;
    logic signed [W-1:0] bh;
    logic signed [W-1:0] cl;
    logic signed [W-1:0] ch;
    logic signed [W-1:0] t;
  } ival_item_t;

  typedef struct packed {
    logic [W-1:0] lo;
    logic [W-1:0] hi;
    logic [1:0]   st;
  } ival_res_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [iau_pkg::ZG_BITS-1:0] cfg_wdata = '0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [5*W-1:0]              in_tdata = '0;
  logic [3:0]                  in_tuser = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [2*W-1:0]              out_tdata;
  logic [1:0]                  out_tuser;

  ival_item_t pending_items[$];
  ival_res_t  expected_results[$];
  logic [15:0] guard_model = '0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;   // long stretch with no idling

  interval_arithmetic_unit dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clamp a wide value to the word range
  function automatic logic signed [63:0] clamp_w(input logic signed [65:0] v,
                                                 inout bit s);
    if (v > SMAX) begin
      s = 1'b1;
      return SMAX;
    end
    if (v < SMIN) begin
      s = 1'b1;
      return SMIN;
    end
    return v[63:0];
  endfunction

  // signed word from sign and magnitude, clamped
  function automatic logic signed [63:0] signed_of(input bit neg, input logic [127:0] m,
                                                   inout bit s);
    if (!neg) begin
      if (m > 128'(SMAX)) begin
        s = 1'b1;
        return SMAX;
      end
      return 64'(m);
    end
    if (m > 128'h8000_0000) begin
      s = 1'b1;
      return SMIN;
    end
    return -$signed({1'b0, 64'(m)});
  endfunction

  // fixed-point product rounded toward -inf (up=0) or +inf (up=1)
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b,
                                              input bit up, inout bit s);
    bit neg;
    logic [127:0] p, m;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = p >> F;
    if ((p[F-1:0] != 0) && (up != neg)) m++;
    return signed_of(neg, m, s);
  endfunction

  function automatic logic signed [63:0] qsqrt(input logic signed [63:0] x, input bit up,
                                               inout bit s);
    logic [127:0] n, r, c;
    n = 128'(x) << F;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'(1) << i);
      if (c * c <= n) r = c;
    end
    if (up && r * r != n) r++;
    return signed_of(1'b0, r, s);
  endfunction

  function automatic logic signed [63:0] qrecip(input logic signed [63:0] x, input bit up,
                                                inout bit s);
    logic [127:0] num, m, q;
    bit neg;
    if (x == 0) begin
      s = 1'b1;
      return up ? SMAX : SMIN;
    end
    neg = x < 0;
    num = 128'(1) << (2 * F);
    m = 128'(neg ? -x : x);
    q = num / m;
    if ((num % m) != 0 && up != neg) q++;
    return signed_of(neg, q, s);
  endfunction

  function automatic ival_res_t interval_result(input ival_item_t it,
                                                input logic [15:0] guard);
    logic signed [63:0] bl, bh, cl, ch, t, lo, hi, u, g;
    bit s;
    ival_res_t r;
    bl = it.bl; bh = it.bh; cl = it.cl; ch = it.ch; t = it.t;
    g = {48'd0, guard};
    lo = 0; hi = 0; s = 1'b0;
    r.st = iau_pkg::ST_OK;
    case (it.mode)
      iau_pkg::MODE_PASS: begin
        lo = bl; hi = bh;
      end
      iau_pkg::MODE_NEG: begin
        lo = clamp_w(-66'(bh), s); hi = clamp_w(-66'(bl), s);
      end
      iau_pkg::MODE_SCALE: begin
        if (t > 0) begin
          lo = qmul(t, bl, 0, s); hi = qmul(t, bh, 1, s);
        end else begin
          lo = qmul(t, bh, 0, s); hi = qmul(t, bl, 1, s);
        end
      end
      iau_pkg::MODE_TRANS: begin
        lo = clamp_w(66'(t) + 66'(bl), s); hi = clamp_w(66'(t) + 66'(bh), s);
      end
      iau_pkg::MODE_ADD: begin
        lo = clamp_w(66'(bl) + 66'(cl), s); hi = clamp_w(66'(bh) + 66'(ch), s);
      end
      iau_pkg::MODE_SUB: begin
        lo = clamp_w(66'(bl) - 66'(ch), s); hi = clamp_w(66'(bh) - 66'(cl), s);
      end
      iau_pkg::MODE_MUL: begin
        if (bl >= 0) begin
          if (cl >= 0) begin
            lo = qmul(bl, cl, 0, s); hi = qmul(bh, ch, 1, s);
          end else if (ch <= 0) begin
            lo = qmul(bh, cl, 0, s); hi = qmul(bl, ch, 1, s);
          end else begin
            lo = qmul(bh, cl, 0, s); hi = qmul(bh, ch, 1, s);
          end
        end else if (bh <= 0) begin
          if (cl >= 0) begin
            lo = qmul(bl, ch, 0, s); hi = qmul(bh, cl, 1, s);
          end else if (ch <= 0) begin
            lo = qmul(bh, ch, 0, s); hi = qmul(bl, cl, 1, s);
          end else begin
            lo = qmul(bl, ch, 0, s); hi = qmul(bl, cl, 1, s);
          end
        end else begin
          if (cl >= 0) begin
            lo = qmul(bl, ch, 0, s); hi = qmul(bh, ch, 1, s);
          end else if (ch <= 0) begin
            lo = qmul(bh, cl, 0, s); hi = qmul(bl, cl, 1, s);
          end else begin
            lo = qmul(bl, ch, 0, s);
            u = qmul(bh, cl, 0, s);
            if (u < lo) lo = u;
            hi = qmul(bl, cl, 1, s);
            u = qmul(bh, ch, 1, s);
            if (u > hi) hi = u;
          end
        end
      end
      iau_pkg::MODE_SQR: begin
        if (bl >= 0) begin
          lo = qmul(bl, bl, 0, s); hi = qmul(bh, bh, 1, s);
        end else if (bh <= 0) begin
          lo = qmul(bh, bh, 0, s); hi = qmul(bl, bl, 1, s);
        end else begin
          hi = qmul(bl, bl, 1, s);
          u = qmul(bh, bh, 1, s);
          if (u > hi) hi = u;
        end
      end
      iau_pkg::MODE_INV: begin
        if (bl <= g && bh >= -g) begin
          lo = SMIN; hi = SMAX;
        end else begin
          lo = qrecip(bh, 0, s); hi = qrecip(bl, 1, s);
        end
      end
      iau_pkg::MODE_SQRT: begin
        if (bh < 0) r.st = iau_pkg::ST_DOMAIN;
        else begin
          lo = bl <= 0 ? 0 : qsqrt(bl, 0, s);
          hi = bh <= 0 ? 0 : qsqrt(bh, 1, s);
        end
      end
      iau_pkg::MODE_WIDTH: begin
        lo = clamp_w(66'(bh) - 66'(bl), s);
        if (lo < 0) lo = clamp_w(-66'(lo), s);
      end
      default: ;
    endcase
    if (r.st == iau_pkg::ST_OK && s) r.st = iau_pkg::ST_SAT;
    r.lo = lo[W-1:0];
    r.hi = hi[W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3, 4: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
      5, 6: return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000);
      default: return $urandom;
    endcase
  endfunction

  function automatic ival_item_t rand_item();
    ival_item_t it;
    logic [31:0] x, y;
    it.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, 10));
    x = rand_word(); y = rand_word();
    // mostly ordered intervals, some reversed
    if ($urandom_range(0, 9) != 0 && $signed(x) > $signed(y)) begin
      it.bl = y; it.bh = x;
    end else begin
      it.bl = x; it.bh = y;
    end
    x = rand_word(); y = rand_word();
    if ($urandom_range(0, 9) != 0 && $signed(x) > $signed(y)) begin
      it.cl = y; it.ch = x;
    end else begin
      it.cl = x; it.ch = y;
    end
    it.t = rand_word();
    return it;
  endfunction

  function automatic ival_item_t mk(input logic [3:0] m, input logic [31:0] bl,
                                    input logic [31:0] bh, input logic [31:0] cl,
                                    input logic [31:0] ch, input logic [31:0] t);
    ival_item_t it;
    it.mode = m; it.bl = bl; it.bh = bh; it.cl = cl; it.ch = ch; it.t = t;
    return it;
  endfunction

  // driver: pops pending items, random idling
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          ival_item_t it;
          it = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= it.mode;
          in_tdata <= {it.t, it.ch, it.cl, it.bh, it.bl};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || $urandom_range(0, 99) >= 18;
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      ival_item_t it;
      it = mk(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
              in_tdata[127:96], in_tdata[159:128]);
      expected_results.push_back(interval_result(it, guard_model));
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result item %h %h", out_tdata, out_tuser);
      end else begin
        ival_res_t e;
        e = expected_results.pop_front();
        if (out_tdata[31:0] !== e.lo || out_tdata[63:32] !== e.hi || out_tuser !== e.st) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp lo=%h hi=%h st=%0d got lo=%h hi=%h st=%0d",
                     e.lo, e.hi, e.st, out_tdata[31:0], out_tdata[63:32], out_tuser);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_guard(input logic [15:0] v);
    // wait out everything in flight
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    guard_model = v;
  endtask

  task automatic guard_checks(input logic [15:0] g);
    pending_items.push_back(mk(iau_pkg::MODE_INV, -32'(g), 32'(g), 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_INV, 32'(g) + 1, 32'h0001_0000, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_INV, 32'h8000_0000, -32'(g) - 1, 0, 0, 0));
  endtask

  initial begin
    logic [15:0] guards[4];
    guards = '{16'd0, 16'hFFFF, 16'd5, 16'h0100};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_guard(16'd0);
    // directed: extremes, every opcode and special cases
    pending_items.push_back(mk(iau_pkg::MODE_PASS, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SCALE, 32'hFFFF_0000, 32'h0003_8000, 0, 0,
                               32'h0002_0001));
    pending_items.push_back(mk(iau_pkg::MODE_SCALE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                               32'hFFFF_0000));
    pending_items.push_back(mk(iau_pkg::MODE_SCALE, 1, 3, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_TRANS, 32'h7FFF_0000, 32'h7FFF_FFFF, 0, 0,
                               32'h0001_0000));
    pending_items.push_back(mk(iau_pkg::MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 0));
    pending_items.push_back(mk(iau_pkg::MODE_MUL, 32'hFFFE_0000, 32'h0003_0000,
                               32'hFFFF_8000, 32'h0002_0000, 0));
    pending_items.push_back(mk(iau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SQR, 32'hFFFD_0000, 32'h0002_0000, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SQR, 32'h0100_0000, 32'h7FFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_INV, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_INV, 32'h0001_0000, 0, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_INV, 32'h0000_0003, 32'h0000_0001, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_INV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SQRT, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SQRT, 32'hFFFF_0000, 32'h0002_0000, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_SQRT, 32'h0000_0002, 32'h7FFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_WIDTH, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    pending_items.push_back(mk(iau_pkg::MODE_WIDTH, 32'h0005_0000, 32'h0001_0000, 0, 0, 0));
    pending_items.push_back(mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(mk(4'd11, 0, 0, 0, 0, 0));
    // random phases, each under its own guard setting
    for (int ph = 0; ph < 4; ph++) begin
      write_guard(guards[ph]);
      guard_checks(guards[ph]);
      calm = (ph == 2);
      for (int i = 0; i < 260; i++) pending_items.push_back(rand_item());
    end
    calm = 1'b0;
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ interval_arithmetic_unit.f @@
+incdir+sv
sv/iau_pkg.sv
sv/iau_front.sv
sv/iau_cell.sv
sv/iau_back.sv
sv/interval_arithmetic_unit.sv
sim/interval_arithmetic_unit_test.sv
